/* rtl/kes_pkg.sv */
`timescale 1ns / 1ps

package kes_pkg;

  localparam int WFB = 60;
  localparam logic [63:0] WONE = 64'd1 << WFB;
  localparam logic [31:0] ECC_ONE = 32'h1000_0000;
  localparam logic [63:0] SAT_MAG = 64'd1 << 62;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_PARABOLIC = 2'd2;

  localparam logic [1:0] CFG_TOLERANCE  = 2'd0;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd1;

  typedef logic [63:0][63:0] tab_t;

  typedef struct packed {
    logic start;
    logic hyp;
  } cordic_cmd_t;

  function automatic logic [63:0] asr64(input logic [63:0] v, input int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] pow2_series(input int i, input logic alt);
    logic [63:0] sum;
    logic [63:0] t;
    int ex;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      ex = i * (2 * k + 1);
      if (ex <= WFB) begin
        t = const_udiv(64'd1 << (WFB - ex), 64'(2 * k + 1));
        if (alt && k[0]) sum = sum - t;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] inv_series(input logic [63:0] n, input logic alt);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic run;
    p = const_udiv(WONE, n);
    sum = p;
    run = 1'b1;
    for (int k = 1; k < 64; k++) begin
      if (run) begin
        p = const_udiv(p, n * n);
        if (p == 64'd0) begin
          run = 1'b0;
        end else begin
          t = const_udiv(p, 64'(2 * k + 1));
          if (alt && k[0]) sum = sum - t;
          else sum = sum + t;
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_pi();
    return 64'd4 * inv_series(64'd5, 1'b1) - inv_series(64'd239, 1'b1);
  endfunction

  function automatic tab_t atan_table();
    tab_t t;
    t[0] = quarter_pi();
    for (int i = 1; i < 64; i++) t[i] = pow2_series(i, 1'b1);
    return t;
  endfunction

  function automatic tab_t atanh_table();
    tab_t t;
    t[0] = '0;
    for (int i = 1; i < 64; i++) t[i] = pow2_series(i, 1'b0);
    return t;
  endfunction

  function automatic logic [63:0] const_div_frac(input logic [63:0] num, input logic [63:0] den,
                                                 input int shift, input logic [63:0] cap);
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    logic sat;
    d = (den == 64'd0) ? 64'd1 : den;
    q = const_udiv(num, d);
    r = num - q * d;
    sat = (q > cap);
    for (int s = 0; s < shift; s++) begin
      if (!sat) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
        if (q > cap) sat = 1'b1;
      end
    end
    return sat ? cap : q;
  endfunction

  function automatic logic [63:0] circ_inv_gain(input int stages);
    tab_t tab;
    logic [63:0] x, y, z, dx, dy;
    tab = atan_table();
    x = WONE;
    y = '0;
    z = '0;
    for (int i = 0; i < stages; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (!z[63]) begin
        x = x - dx; y = y + dy; z = z - tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + tab[i];
      end
    end
    return const_div_frac(WONE, x, WFB, SAT_MAG);
  endfunction

  function automatic logic [191:0] hyp_rot(input logic [191:0] v, input int i,
                                           input logic [63:0] a);
    logic [63:0] x, y, z, dx, dy;
    x = v[191:128];
    y = v[127:64];
    z = v[63:0];
    dx = asr64(y, i);
    dy = asr64(x, i);
    if (!z[63]) begin
      x = x + dx; y = y + dy; z = z - a;
    end else begin
      x = x - dx; y = y - dy; z = z + a;
    end
    return {x, y, z};
  endfunction

  function automatic logic [63:0] hyp_inv_gain(input int stages);
    tab_t tab;
    logic [191:0] v;
    int i, rep, cnt;
    tab = atanh_table();
    v = {WONE, 64'd0, 64'd0};
    i = 1;
    rep = 4;
    cnt = 0;
    for (int n = 0; n < 2 * stages + 2; n++) begin
      if (cnt < stages && i < 64) begin
        v = hyp_rot(v, i, tab[i]);
        cnt = cnt + 1;
        if (i == rep && cnt < stages) begin
          v = hyp_rot(v, i, tab[i]);
          cnt = cnt + 1;
          rep = 3 * rep + 1;
        end
        i = i + 1;
      end
    end
    return const_div_frac(WONE, v[191:128], WFB, SAT_MAG);
  endfunction

  localparam logic [63:0] HALF_PI_W = 64'd2 * quarter_pi();
  localparam logic [63:0] LN2_W = 64'd2 * inv_series(64'd3, 1'b0);

endpackage

/* rtl/kepler_equation_solver.sv */
`timescale 1ns / 1ps

// Kepler equation solver. An input word carries a mean anomaly (signed Q5.26)
// and an eccentricity (unsigned Q4.28) on a valid/ready channel; one result
// word leaves on a second valid/ready channel with the eccentric or hyperbolic
// anomaly, a status code, the number of Newton updates and the orbit form.
// Tolerance and iteration limit are set through the configuration channel,
// which is always ready and should only be written while the solver is idle.
// The solver works on one word at a time. Each Newton update consists of an
// argument reduction on the shared restoring divider, a pass of the iterative
// CORDIC unit, the products on the shared multiplier and a quotient on the
// same divider. An elliptic word first makes an extra pass for its starting
// guess, and an eccentricity of exactly one returns a parabolic result with
// no Newton update. The result waits in an output register, so the next word
// is accepted while a stalled receiver holds the previous result; the solver
// only stops when a second result is ready and the first is still waiting.
// Reset returns the sequencer to idle, empties the output register and sets
// the tolerance to 1 and the iteration limit to 50.
module kepler_equation_solver #(
  parameter int ANGLE_FRACTION_BITS = 26,
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] mean_anomaly,
  input  logic [31:0]        eccentricity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] anomaly,
  output logic [1:0]         status,
  output logic [5:0]         iterations_used,
  output logic               is_hyperbolic,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  import kes_pkg::*;

  localparam int F = ANGLE_FRACTION_BITS;
  localparam int S = WFB - F;
  localparam int QRB = (F < 31) ? 33 - F : 2;
  localparam int DW = (64 + F > 97) ? 65 + F : 98;
  localparam int QW = 35;
  localparam int SW = 6;
  localparam int TRUNC = 58 - F;
  localparam logic [63:0] ONE_F = 64'd1 << F;
  localparam logic [DW-1:0] RED_DEN_CIRC = DW'(HALF_PI_W) << QRB;
  localparam logic [DW-1:0] RED_DEN_HYP = DW'(LN2_W) << QRB;
  localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;
  localparam logic signed [31:0] SH_BASE = 32'(F - 59);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0_0000_0000_0001,
    S_CHECK     = 13'b0_0000_0000_0010,
    S_REDUCE    = 13'b0_0000_0000_0100,
    S_RED_WAIT  = 13'b0_0000_0000_1000,
    S_CORD_WAIT = 13'b0_0000_0001_0000,
    S_MUL_A     = 13'b0_0000_0010_0000,
    S_MUL_B     = 13'b0_0000_0100_0000,
    S_MUL_C     = 13'b0_0000_1000_0000,
    S_EVAL      = 13'b0_0001_0000_0000,
    S_RESID     = 13'b0_0010_0000_0000,
    S_TEST      = 13'b0_0100_0000_0000,
    S_DIV_WAIT  = 13'b0_1000_0000_0000,
    S_FINISH    = 13'b1_0000_0000_0000
  } state_t;

  state_t state;

  logic [15:0]        tolerance;
  logic [5:0]         iteration_limit;
  logic signed [31:0] m;
  logic [31:0]        ecc;
  logic               hyp;
  logic               init;
  logic signed [31:0] est;
  logic [5:0]         used;
  logic [1:0]         fin_status;
  logic [31:0]        arg_mag;
  logic               arg_neg;
  logic [QRB-1:0]     k;
  logic [1:0]         qlo;
  logic [63:0]        sv, cv, prod, ta, tb, t1, der, res;
  logic               neg_dir;

  logic               div_start, div_done;
  logic [DW-1:0]      div_num, div_den, div_rem;
  logic [SW-1:0]      div_steps;
  logic [QW-1:0]      div_quo;
  cordic_cmd_t        cord_cmd;
  logic [63:0]        cord_z, cord_x, cord_y;
  logic               cord_done;

  logic [31:0]        mul_in;
  logic [63:0]        mul_out;
  logic signed [31:0] k_ext, sh_amt;
  logic [63:0]        shl_out;
  logic [63:0]        rm, dm, es, ec, ch_sum, sh_val, ex_sum, emx_sum;
  logic [QRB-1:0]     qneg;
  logic [63:0]        unit_w, red_r;
  logic [33:0]        step;
  logic [63:0]        step_sum;

  function automatic logic [31:0] mag30(input logic [63:0] v);
    logic [63:0] a;
    a = v[63] ? -v : v;
    a = a >> 30;
    return (a > 64'h8000_0000) ? 32'h8000_0000 : a[31:0];
  endfunction

  function automatic logic [63:0] shl_sat(input logic [63:0] v, input logic signed [31:0] s);
    logic [63:0] r;
    if (s < 0) begin
      if (s <= -32'sd64) r = '0;
      else r = v >> (-s);
    end else if (v == 64'd0) begin
      r = '0;
    end else if (s >= 32'sd62 || v > (SAT_MAG >> s)) begin
      r = SAT_MAG;
    end else begin
      r = v << s;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic [63:0] v);
    logic signed [63:0] sv64;
    sv64 = $signed(v);
    if (sv64 > 64'sd2147483647) return 32'sh7fff_ffff;
    if (sv64 < -64'sd2147483648) return 32'sh8000_0000;
    return sv64[31:0];
  endfunction

  kes_divider #(.DW(DW), .QW(QW), .SW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  kes_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cord_cmd),
    .z_in  (cord_z),
    .done  (cord_done),
    .x_out (cord_x),
    .y_out (cord_y)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign mul_in = (state == S_MUL_A) ? mag30(sv) : mag30(cv);
  assign mul_out = ecc * mul_in;

  assign k_ext = $signed({{(32-QRB){1'b0}}, k});
  assign sh_amt = (state == S_MUL_B) ? (k_ext + SH_BASE) : (SH_BASE - k_ext);
  assign shl_out = shl_sat(prod, sh_amt);

  assign rm = res[63] ? -res : res;
  assign dm = (der == 64'd0) ? 64'd1 : (der[63] ? -der : der);

  assign div_start = (state == S_REDUCE) || (state == S_TEST && rm >= {48'd0, tolerance});
  assign div_num = (state == S_REDUCE) ? (DW'(arg_mag) << S) : (DW'(rm) << F);
  assign div_den = (state == S_REDUCE) ? (hyp ? RED_DEN_HYP : RED_DEN_CIRC) : (DW'(dm) << 34);
  assign div_steps = (state == S_REDUCE) ? SW'(QRB + 1) : SW'(QW);

  assign unit_w = hyp ? LN2_W : HALF_PI_W;
  assign qneg = -div_quo[QRB-1:0];
  assign red_r = (arg_neg && div_rem[63:0] != 64'd0) ? unit_w - div_rem[63:0] : div_rem[63:0];
  assign cord_cmd.start = (state == S_RED_WAIT) && div_done;
  assign cord_cmd.hyp = hyp;
  assign cord_z = (arg_neg && div_rem[63:0] == 64'd0) ? 64'd0 : red_r;

  assign ex_sum = cord_x + cord_y;
  assign emx_sum = cord_x - cord_y;

  assign es = sv[63] ? -ta : ta;
  assign ec = cv[63] ? -tb : tb;
  assign ch_sum = (ta + tb > SAT_MAG) ? SAT_MAG : ta + tb;
  assign sh_val = (ta > tb) ? ta - tb : 64'd0;

  assign step = (div_quo[34] || div_quo[33:0] > STEP_CAP) ? STEP_CAP : div_quo[33:0];
  assign step_sum = neg_dir ? {{32{est[31]}}, est} + 64'(step)
                            : {{32{est[31]}}, est} - 64'(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 16'd1;
      iteration_limit <= 6'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOLERANCE:  tolerance <= cfg_data;
        CFG_ITER_LIMIT: iteration_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (eccentricity == ECC_ONE) state <= S_FINISH;
            else if (eccentricity > ECC_ONE) state <= S_CHECK;
            else state <= S_REDUCE;
          end
        end
        S_CHECK:     state <= (used < iteration_limit) ? S_REDUCE : S_FINISH;
        S_REDUCE:    state <= S_RED_WAIT;
        S_RED_WAIT:  if (div_done) state <= S_CORD_WAIT;
        S_CORD_WAIT: if (cord_done) state <= S_MUL_A;
        S_MUL_A:     state <= S_MUL_B;
        S_MUL_B:     state <= S_MUL_C;
        S_MUL_C:     state <= S_EVAL;
        S_EVAL:      state <= init ? S_CHECK : S_RESID;
        S_RESID:     state <= S_TEST;
        S_TEST:      state <= div_start ? S_DIV_WAIT : S_FINISH;
        S_DIV_WAIT:  if (div_done) state <= S_CHECK;
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        m <= mean_anomaly;
        ecc <= eccentricity;
        used <= '0;
        hyp <= (eccentricity > ECC_ONE);
        init <= (eccentricity < ECC_ONE);
        est <= (eccentricity == ECC_ONE) ? 32'sd0 : mean_anomaly;
        fin_status <= (eccentricity == ECC_ONE) ? ST_PARABOLIC : ST_LIMIT;
        arg_mag <= mean_anomaly[31] ? -mean_anomaly : mean_anomaly;
        arg_neg <= mean_anomaly[31];
      end
      S_CHECK: begin
        init <= 1'b0;
        arg_mag <= est[31] ? -est : est;
        arg_neg <= est[31] && !hyp;
        fin_status <= ST_LIMIT;
      end
      S_RED_WAIT: begin
        k <= div_quo[QRB-1:0];
        if (!arg_neg) qlo <= div_quo[1:0];
        else if (div_rem[63:0] == 64'd0) qlo <= qneg[1:0];
        else qlo <= qneg[1:0] - 2'd1;
      end
      S_CORD_WAIT: begin
        if (hyp) begin
          sv <= ex_sum[63] ? 64'd0 : ex_sum;
          cv <= emx_sum[63] ? 64'd0 : emx_sum;
        end else begin
          case (qlo)
            2'd0: begin sv <= cord_y;  cv <= cord_x;  end
            2'd1: begin sv <= cord_x;  cv <= -cord_y; end
            2'd2: begin sv <= -cord_y; cv <= -cord_x; end
            default: begin sv <= -cord_x; cv <= cord_y; end
          endcase
        end
      end
      S_MUL_A: prod <= mul_out;
      S_MUL_B: begin
        ta <= hyp ? shl_out : prod >> TRUNC;
        prod <= mul_out;
      end
      S_MUL_C: tb <= hyp ? shl_out : prod >> TRUNC;
      S_EVAL: begin
        if (init) est <= sat32({{32{m[31]}}, m} + es);
        if (hyp) begin
          t1 <= est[31] ? -sh_val : sh_val;
          der <= ch_sum - ONE_F;
        end else begin
          t1 <= es;
          der <= ONE_F - ec;
        end
      end
      S_RESID: begin
        if (hyp) res <= t1 - {{32{est[31]}}, est} - {{32{m[31]}}, m};
        else res <= {{32{est[31]}}, est} - t1 - {{32{m[31]}}, m};
      end
      S_TEST: begin
        neg_dir <= (res[63] != der[63]);
        if (!div_start) fin_status <= ST_CONVERGED;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          est <= sat32(step_sum);
          used <= used + 6'd1;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          anomaly <= est;
          status <= fin_status;
          iterations_used <= used;
          is_hyperbolic <= hyp;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/kes_divider.sv */
`timescale 1ns / 1ps

module kes_divider #(
  parameter int DW = 98,
  parameter int QW = 35,
  parameter int SW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] steps,
  output logic          done,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] dsh;
  logic [SW-1:0] cnt;
  logic          busy;
  logic          ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == SW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= den;
      quo <= '0;
      cnt <= steps;
    end else if (busy) begin
      if (ge) rem <= rem - dsh;
      quo <= {quo[QW-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - SW'(1);
    end
  end

endmodule

/* rtl/kes_cordic.sv */
`timescale 1ns / 1ps

module kes_cordic #(
  parameter int STAGES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  kes_pkg::cordic_cmd_t cmd,
  input  logic [63:0]         z_in,
  output logic                done,
  output logic [63:0]         x_out,
  output logic [63:0]         y_out
);

  import kes_pkg::*;

  localparam int CW = $clog2(STAGES + 1);
  localparam tab_t ATAN_T = atan_table();
  localparam tab_t ATANH_T = atanh_table();
  localparam logic [63:0] CIRC_GAIN = circ_inv_gain(STAGES);
  localparam logic [63:0] HYP_GAIN = hyp_inv_gain(STAGES);

  logic [63:0]   z;
  logic [5:0]    idx;
  logic [7:0]    rep;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          dup;
  logic          hyp;
  logic          busy;
  logic          last;
  logic [63:0]   dx, dy, angle;

  assign dx = asr64(y_out, int'(idx));
  assign dy = asr64(x_out, int'(idx));
  assign angle = hyp ? ATANH_T[idx] : ATAN_T[idx];
  assign cnt_next = cnt + CW'(1);
  assign last = (cnt_next == CW'(STAGES));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_out <= cmd.hyp ? HYP_GAIN : CIRC_GAIN;
      y_out <= '0;
      z     <= z_in;
      idx   <= cmd.hyp ? 6'd1 : 6'd0;
      rep   <= 8'd4;
      cnt   <= '0;
      dup   <= 1'b0;
      hyp   <= cmd.hyp;
    end else if (busy) begin
      cnt <= cnt_next;
      if (hyp) begin
        if (!z[63]) begin
          x_out <= x_out + dx; y_out <= y_out + dy; z <= z - angle;
        end else begin
          x_out <= x_out - dx; y_out <= y_out - dy; z <= z + angle;
        end
        if (dup) begin
          dup <= 1'b0;
          idx <= idx + 6'd1;
        end else if ({2'b00, idx} == rep && !last) begin
          dup <= 1'b1;
          rep <= 8'd3 * rep + 8'd1;
        end else begin
          idx <= idx + 6'd1;
        end
      end else begin
        if (!z[63]) begin
          x_out <= x_out - dx; y_out <= y_out + dy; z <= z - angle;
        end else begin
          x_out <= x_out + dx; y_out <= y_out - dy; z <= z + angle;
        end
        idx <= idx + 6'd1;
      end
    end
  end

endmodule

/* rtl/kes_checker.sv */
`timescale 1ns / 1ps

module kes_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] anomaly,
  input logic [1:0]         status,
  input logic [5:0]         iterations_used,
  input logic               is_hyperbolic
);

  import kes_pkg::*;

  // The solver holds one word at a time, so an accepted word closes the input.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_CONVERGED || status == ST_LIMIT || status == ST_PARABOLIC))
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_PARABOLIC |->
      anomaly == 32'sd0 && iterations_used == 6'd0 && !is_hyperbolic)
    else $error("parabolic result is not empty");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(anomaly) && $stable(status))
    else $error("stalled result changed");

endmodule

bind kepler_equation_solver kes_checker u_kes_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .anomaly         (anomaly),
  .status          (status),
  .iterations_used (iterations_used),
  .is_hyperbolic   (is_hyperbolic)
);
